/* src/sfs_pkg.sv */
`timescale 1ns / 1ps

package sfs_pkg;

    // Command codes
    localparam logic [2:0] CMD_TICK         = 3'd0;
    localparam logic [2:0] CMD_PLAY         = 3'd1;
    localparam logic [2:0] CMD_ENQUEUE      = 3'd2;
    localparam logic [2:0] CMD_STOP         = 3'd3;
    localparam logic [2:0] CMD_ADD_EVENT    = 3'd4;
    localparam logic [2:0] CMD_CLEAR_EVENTS = 3'd5;

    localparam logic [15:0] GAIN_RESET = 16'd256;
    localparam int          MASK_W     = 8;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] time_step;
        logic [7:0]  clip_id;
        logic [8:0]  frame_count;
        logic [15:0] frame_period;
        logic        loop_mode;
        logic        clear_queue;
        logic [7:0]  event_frame;
    } sfs_in_t;

    typedef struct packed {
        logic [7:0] shown_clip;
        logic [7:0] frame_index;
        logic       is_playing;
        logic [7:0] event_mask;
        logic       push_dropped;
    } sfs_out_t;

    typedef struct packed {
        logic [7:0]  clip;
        logic [8:0]  length;
        logic [15:0] period;
        logic        loop;
    } sfs_clip_t;

    typedef struct packed {
        logic       add;
        logic       clear;
        logic [7:0] add_clip;
        logic [7:0] add_frame;
        logic [7:0] match_clip;
        logic [8:0] match_frame;
    } sfs_evt_ctrl_t;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              full;
    } sfs_evt_stat_t;

endpackage

/* src/sprite_frame_sequencer.sv */
`timescale 1ns / 1ps
// An accepted item waits in the input stage register, then its result in the
// result register. Throughput: one item per cycle while m_ready is high; the
// time product is registered in the input stage, and the state update plus
// event match complete in the next stage.
// Reset (aresetn low, synchronous): playback stopped, queue and event table
// empty, speed_gain back to 256, both pipeline stages empty.

module sprite_frame_sequencer #(
    parameter int QUEUE_DEPTH = 4,
    parameter int EVENT_SLOTS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sfs_pkg::sfs_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sfs_pkg::sfs_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Configuration: always take the write, block is idle by contract.
    logic [15:0] speed_gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_gain_reg <= sfs_pkg::GAIN_RESET;
        end else if (cfg_valid) begin
            speed_gain_reg <= cfg_data;
        end
    end

    // Input stage: hold the item and its scaled time step.
    logic             a_valid_reg;
    sfs_pkg::sfs_in_t a_item_reg;
    logic [31:0]      a_prod_reg;
    logic             s_accept;
    logic             adv;
    logic             m_valid_reg;
    sfs_pkg::sfs_out_t m_data_reg;
    sfs_pkg::sfs_out_t m_data_next;

    // Advance the input stage when the result register is free or draining.
    assign adv      = a_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !a_valid_reg || adv;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_accept) begin
            a_valid_reg <= 1'b1;
        end else if (adv) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_item_reg <= s_data;
            a_prod_reg <= 32'(s_data.time_step) * 32'(speed_gain_reg);
        end
    end

    // Playback state
    logic        playing_reg,  playing_next;
    logic [31:0] acc_reg,      acc_next;
    logic [7:0]  clip_reg,     clip_next;
    logic [8:0]  frame_reg,    frame_next;
    logic [8:0]  length_reg,   length_next;
    logic [15:0] period_reg,   period_next;
    logic        loop_reg,     loop_next;
    logic [CW-1:0] count_reg,  count_next;
    sfs_pkg::sfs_clip_t queue_reg [QUEUE_DEPTH];

    logic        push;
    logic        pop;
    logic        dropped;
    logic        match_en;
    logic [32:0] sum;
    logic [31:0] acc_sat;
    logic        reach;
    logic [8:0]  frame_inc;
    sfs_pkg::sfs_clip_t head;
    sfs_pkg::sfs_clip_t new_clip;
    sfs_pkg::sfs_evt_ctrl_t evt_ctrl;
    sfs_pkg::sfs_evt_stat_t evt_stat;

    assign head = queue_reg[0];
    assign new_clip = '{clip:   a_item_reg.clip_id,
                        length: a_item_reg.frame_count,
                        period: a_item_reg.frame_period,
                        loop:   a_item_reg.loop_mode};

    always_comb begin
        playing_next = playing_reg;
        acc_next     = acc_reg;
        clip_next    = clip_reg;
        frame_next   = frame_reg;
        length_next  = length_reg;
        period_next  = period_reg;
        loop_next    = loop_reg;
        count_next   = count_reg;
        push         = 1'b0;
        pop          = 1'b0;
        dropped      = 1'b0;
        match_en     = 1'b0;
        evt_ctrl.add   = 1'b0;
        evt_ctrl.clear = 1'b0;

        // Saturate the accumulator at all ones.
        sum       = {1'b0, acc_reg} + {1'b0, a_prod_reg};
        acc_sat   = sum[32] ? '1 : sum[31:0];
        reach     = acc_sat >= {8'h00, period_reg, 8'h00};
        frame_inc = frame_reg + 9'd1;

        if (adv) begin
            case (a_item_reg.cmd)
                sfs_pkg::CMD_TICK: begin
                    if (playing_reg) begin
                        if (!reach) begin
                            acc_next = acc_sat;
                        end else begin
                            acc_next = '0;
                            if (frame_inc >= length_reg) begin
                                if (count_reg != '0) begin
                                    // End of clip: start the queued head, skip events.
                                    pop          = 1'b1;
                                    count_next   = count_reg - CW'(1);
                                    clip_next    = head.clip;
                                    length_next  = (head.length == '0) ? 9'd1 : head.length;
                                    period_next  = head.period;
                                    loop_next    = head.loop;
                                    frame_next   = '0;
                                    playing_next = 1'b1;
                                end else if (loop_reg) begin
                                    frame_next = '0;
                                    match_en   = 1'b1;
                                end else begin
                                    // Hold the last frame and stop.
                                    frame_next   = length_reg - 9'd1;
                                    playing_next = 1'b0;
                                    match_en     = 1'b1;
                                end
                            end else begin
                                frame_next = frame_inc;
                                match_en   = 1'b1;
                            end
                        end
                    end
                end
                sfs_pkg::CMD_PLAY: begin
                    if (a_item_reg.clear_queue) begin
                        count_next = '0;
                    end
                    clip_next    = new_clip.clip;
                    length_next  = (new_clip.length == '0) ? 9'd1 : new_clip.length;
                    period_next  = new_clip.period;
                    loop_next    = new_clip.loop;
                    frame_next   = '0;
                    acc_next     = '0;
                    playing_next = 1'b1;
                end
                sfs_pkg::CMD_ENQUEUE: begin
                    if (count_reg < CW'(QUEUE_DEPTH)) begin
                        push       = 1'b1;
                        count_next = count_reg + CW'(1);
                    end else begin
                        dropped = 1'b1;
                    end
                end
                sfs_pkg::CMD_STOP: begin
                    playing_next = 1'b0;
                end
                sfs_pkg::CMD_ADD_EVENT: begin
                    evt_ctrl.add = !evt_stat.full;
                    dropped      = evt_stat.full;
                end
                sfs_pkg::CMD_CLEAR_EVENTS: begin
                    evt_ctrl.clear = 1'b1;
                end
                default: begin
                end
            endcase
        end

        evt_ctrl.add_clip    = a_item_reg.clip_id;
        evt_ctrl.add_frame   = a_item_reg.event_frame;
        evt_ctrl.match_clip  = clip_reg;
        evt_ctrl.match_frame = frame_next;

        m_data_next.shown_clip   = clip_next;
        m_data_next.frame_index  = frame_next[7:0];
        m_data_next.is_playing   = playing_next;
        m_data_next.event_mask   = match_en ? evt_stat.mask : '0;
        m_data_next.push_dropped = dropped;
    end

    sfs_event_table #(
        .EVENT_SLOTS (EVENT_SLOTS)
    ) u_events (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (evt_ctrl),
        .stat    (evt_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            playing_reg <= 1'b0;
            acc_reg     <= '0;
            clip_reg    <= '0;
            frame_reg   <= '0;
            length_reg  <= 9'd1;
            period_reg  <= 16'd1;
            loop_reg    <= 1'b0;
            count_reg   <= '0;
        end else begin
            playing_reg <= playing_next;
            acc_reg     <= acc_next;
            clip_reg    <= clip_next;
            frame_reg   <= frame_next;
            length_reg  <= length_next;
            period_reg  <= period_next;
            loop_reg    <= loop_next;
            count_reg   <= count_next;
        end
    end

    // Pending clip queue: head at entry 0, shift down on pop, write at the tail.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (pop) begin
                if (i < QUEUE_DEPTH - 1) begin
                    queue_reg[i] <= queue_reg[(i + 1) % QUEUE_DEPTH];
                end
            end else if (push && (count_reg[QW-1:0] == QW'(i))) begin
                queue_reg[i] <= new_clip;
            end
        end
    end

    // Result register: load on advance, drop once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The queue never holds more clips than it has entries.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("pending clip count exceeds queue depth");

    // The active frame always lies inside the active clip.
    a_frame_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_reg < length_reg)
        else $error("active frame beyond clip length");

    // An item held in the input stage stays there until it advances.
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !adv |=> a_valid_reg && $stable(a_item_reg))
        else $error("input stage lost a waiting item");

    // Every advance produces a result in the next cycle.
    a_adv_result: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> m_valid_reg)
        else $error("advance did not load the result register");

endmodule

/* src/sfs_event_table.sv */
`timescale 1ns / 1ps

module sfs_event_table #(
    parameter int EVENT_SLOTS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sfs_pkg::sfs_evt_ctrl_t ctrl,
    output sfs_pkg::sfs_evt_stat_t stat
);

    logic [EVENT_SLOTS-1:0] valid_reg;
    logic [EVENT_SLOTS-1:0] valid_next;
    logic [EVENT_SLOTS-1:0] fill_sel;
    logic [7:0]             clip_reg  [EVENT_SLOTS];
    logic [7:0]             frame_reg [EVENT_SLOTS];

    // Pick the lowest free slot.
    always_comb begin
        logic taken;
        taken = 1'b0;
        for (int i = 0; i < EVENT_SLOTS; i++) begin
            fill_sel[i] = !valid_reg[i] && !taken;
            if (!valid_reg[i]) begin
                taken = 1'b1;
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (ctrl.clear) begin
            valid_next = '0;
        end else if (ctrl.add) begin
            valid_next = valid_reg | fill_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < EVENT_SLOTS; i++) begin
            if (ctrl.add && fill_sel[i]) begin
                clip_reg[i]  <= ctrl.add_clip;
                frame_reg[i] <= ctrl.add_frame;
            end
        end
    end

    // Only the first slots own a mask bit; the rest are kept but not reported.
    always_comb begin
        stat.mask = '0;
        for (int i = 0; i < sfs_pkg::MASK_W; i++) begin
            if (i < EVENT_SLOTS) begin
                stat.mask[i] = valid_reg[i] && (clip_reg[i] == ctrl.match_clip) &&
                               ({1'b0, frame_reg[i]} == ctrl.match_frame);
            end
        end
        stat.full = &valid_reg;
    end

endmodule

/* verif/sfs_checker.sv */
`timescale 1ns / 1ps

module sfs_checker #(
    parameter int QUEUE_DEPTH = 4,
    parameter int EVENT_SLOTS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  sfs_pkg::sfs_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  sfs_pkg::sfs_out_t m_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [15:0]       cfg_data,
    output int                err_cnt,
    output int                due_cnt,
    output int                n_checked,
    output int                n_fired,
    output int                n_dropped
);

    localparam int DUE_DEPTH = 16;

    logic [15:0] gain;
    logic        playing;
    logic [31:0] accum;
    logic [7:0]  cur_clip;
    logic [8:0]  cur_frame;
    logic [8:0]  cur_len;
    logic [15:0] cur_period;
    logic        cur_loop;
    sfs_pkg::sfs_clip_t clip_fifo [QUEUE_DEPTH];
    int          fifo_n;
    logic        ev_valid [EVENT_SLOTS];
    logic [7:0]  ev_clip  [EVENT_SLOTS];
    logic [7:0]  ev_frame [EVENT_SLOTS];

    // Expected statuses in order, as a ring with free-running counters.
    sfs_pkg::sfs_out_t status_due [DUE_DEPTH];
    int          due_wr;
    int          due_rd;

    task automatic clear_sequencer();
        gain       = sfs_pkg::GAIN_RESET;
        playing    = 1'b0;
        accum      = '0;
        cur_clip   = '0;
        cur_frame  = '0;
        cur_len    = 9'd1;
        cur_period = 16'd1;
        cur_loop   = 1'b0;
        fifo_n     = 0;
        for (int i = 0; i < EVENT_SLOTS; i++) ev_valid[i] = 1'b0;
    endtask

    task automatic load_clip(input sfs_pkg::sfs_clip_t d);
        cur_clip   = d.clip;
        cur_len    = (d.length == '0) ? 9'd1 : d.length;
        cur_period = d.period;
        cur_loop   = d.loop;
        cur_frame  = '0;
        accum      = '0;
        playing    = 1'b1;
    endtask

    task automatic advance_time(input logic [15:0] step, output logic [7:0] mask);
        logic [31:0] add;
        logic [32:0] sum;
        sfs_pkg::sfs_clip_t head;
        mask = '0;
        if (!playing) return;
        add   = 32'(step) * 32'(gain);
        sum   = {1'b0, accum} + {1'b0, add};
        accum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (accum < {8'd0, cur_period, 8'd0}) return;
        accum     = '0;
        cur_frame = cur_frame + 9'd1;
        if (cur_frame >= cur_len) begin
            if (fifo_n > 0) begin
                // the next clip takes over; no event match on this advance
                head = clip_fifo[0];
                for (int i = 1; i < fifo_n; i++) clip_fifo[i-1] = clip_fifo[i];
                fifo_n--;
                load_clip(head);
                return;
            end
            if (cur_loop) begin
                cur_frame = '0;
            end else begin
                cur_frame = cur_len - 9'd1;
                playing   = 1'b0;
            end
        end
        for (int i = 0; i < EVENT_SLOTS && i < sfs_pkg::MASK_W; i++) begin
            if (ev_valid[i] && ev_clip[i] == cur_clip && {1'b0, ev_frame[i]} == cur_frame)
                mask[i] = 1'b1;
        end
    endtask

    task automatic predict_status(input sfs_pkg::sfs_in_t c, output sfs_pkg::sfs_out_t r);
        sfs_pkg::sfs_clip_t d;
        logic [7:0] mask;
        logic       dropped;
        d       = '{clip: c.clip_id, length: c.frame_count, period: c.frame_period,
                    loop: c.loop_mode};
        mask    = '0;
        dropped = 1'b0;
        case (c.cmd)
            sfs_pkg::CMD_TICK: begin
                advance_time(c.time_step, mask);
            end
            sfs_pkg::CMD_PLAY: begin
                if (c.clear_queue) fifo_n = 0;
                load_clip(d);
            end
            sfs_pkg::CMD_ENQUEUE: begin
                if (fifo_n < QUEUE_DEPTH) begin
                    clip_fifo[fifo_n] = d;
                    fifo_n++;
                end else begin
                    dropped = 1'b1;
                end
            end
            sfs_pkg::CMD_STOP: begin
                playing = 1'b0;
            end
            sfs_pkg::CMD_ADD_EVENT: begin
                dropped = 1'b1;
                for (int i = 0; i < EVENT_SLOTS; i++) begin
                    if (dropped && !ev_valid[i]) begin
                        ev_valid[i] = 1'b1;
                        ev_clip[i]  = c.clip_id;
                        ev_frame[i] = c.event_frame;
                        dropped     = 1'b0;
                    end
                end
            end
            sfs_pkg::CMD_CLEAR_EVENTS: begin
                for (int i = 0; i < EVENT_SLOTS; i++) ev_valid[i] = 1'b0;
            end
            default: ;
        endcase
        r.shown_clip   = cur_clip;
        r.frame_index  = cur_frame[7:0];
        r.is_playing   = playing;
        r.event_mask   = mask;
        r.push_dropped = dropped;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin : watch
        sfs_pkg::sfs_out_t want;
        if (!aresetn) begin
            clear_sequencer();
            due_wr = 0;
            due_rd = 0;
        end else begin
            if (cfg_valid && cfg_ready) gain = cfg_data;
            if (s_valid && s_ready) begin
                predict_status(s_data, want);
                if (due_wr - due_rd >= DUE_DEPTH) begin
                    $display("%0t: status backlog overflow, expected at most %0d, got %0d",
                             $time, DUE_DEPTH, due_wr - due_rd + 1);
                    err_cnt++;
                end else begin
                    status_due[due_wr % DUE_DEPTH] = want;
                    due_wr++;
                end
            end
            if (m_valid && m_ready) begin
                if (due_wr == due_rd) begin
                    $display("%0t: unexpected status, expected none, got %h", $time, m_data);
                    err_cnt++;
                end else begin
                    want = status_due[due_rd % DUE_DEPTH];
                    due_rd++;
                    check_field("shown_clip", want.shown_clip, m_data.shown_clip);
                    check_field("frame_index", want.frame_index, m_data.frame_index);
                    check_field("is_playing", 8'(want.is_playing), 8'(m_data.is_playing));
                    check_field("event_mask", want.event_mask, m_data.event_mask);
                    check_field("push_dropped", 8'(want.push_dropped),
                                8'(m_data.push_dropped));
                    n_checked++;
                    if (want.event_mask != '0) n_fired++;
                    if (want.push_dropped) n_dropped++;
                end
            end
        end
        due_cnt <= due_wr - due_rd;
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

    // Commands the block must ignore; not part of the package.
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam int         LATENCY     = 2;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    sfs_pkg::sfs_in_t  s_data = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    sfs_pkg::sfs_out_t m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    int err_cnt, due_cnt, n_checked, n_fired, n_dropped;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_left    = 0;
    int items_sent   = 0;

    sprite_frame_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sfs_checker checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .err_cnt   (err_cnt),
        .due_cnt   (due_cnt),
        .n_checked (n_checked),
        .n_fired   (n_fired),
        .n_dropped (n_dropped)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Receiver: a pending hold-off counts down here one cycle at a time;
    // otherwise drop ready at random at the current idle rate.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    function automatic sfs_pkg::sfs_in_t make_cmd(
        input logic [2:0]  cmd,
        input logic [15:0] step,
        input logic [7:0]  clip,
        input logic [8:0]  count,
        input logic [15:0] period,
        input logic        loop_on,
        input logic        flush,
        input logic [7:0]  ev_frame
    );
        sfs_pkg::sfs_in_t c;
        c.cmd          = cmd;
        c.time_step    = step;
        c.clip_id      = clip;
        c.frame_count  = count;
        c.frame_period = period;
        c.loop_mode    = loop_on;
        c.clear_queue  = flush;
        c.event_frame  = ev_frame;
        return c;
    endfunction

    // Mostly well-formed commands over a few clip ids, short clips and small
    // periods so frames advance, loops wrap and queued clips get popped;
    // a few items are raw noise across every bit.
    function automatic sfs_pkg::sfs_in_t random_cmd();
        sfs_pkg::sfs_in_t c;
        logic [63:0] raw;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 7) begin
            raw = {$urandom, $urandom};
            c   = raw[$bits(sfs_pkg::sfs_in_t)-1:0];
            return c;
        end
        c.time_step    = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8));
        c.clip_id      = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(3));
        case ($urandom_range(9))
            0:       c.frame_count = 9'd0;
            1:       c.frame_count = 9'd256;
            2:       c.frame_count = 9'($urandom);
            default: c.frame_count = 9'($urandom_range(1, 6));
        endcase
        c.frame_period = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(4));
        c.loop_mode    = 1'($urandom);
        c.clear_queue  = ($urandom_range(3) == 0);
        c.event_frame  = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(5));
        if (pick < 62)      c.cmd = sfs_pkg::CMD_TICK;
        else if (pick < 71) c.cmd = sfs_pkg::CMD_PLAY;
        else if (pick < 83) c.cmd = sfs_pkg::CMD_ENQUEUE;
        else if (pick < 86) c.cmd = sfs_pkg::CMD_STOP;
        else if (pick < 94) c.cmd = sfs_pkg::CMD_ADD_EVENT;
        else if (pick < 97) c.cmd = sfs_pkg::CMD_CLEAR_EVENTS;
        else                c.cmd = ($urandom_range(1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
        return c;
    endfunction

    // Offer one item: idle first at the sender rate, then hold valid and
    // payload until the block takes the item.
    task automatic send_item(input sfs_pkg::sfs_in_t c);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Drop valid and wait until every expected status has come back.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (due_cnt != 0);
    endtask

    // Only write the gain with the pipeline empty.
    task automatic write_gain(input logic [15:0] g);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [15:0] g;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        snd_idle_pct = 9;
        rcv_idle_pct = 79;

        // Directed part at reset gain (1.0).
        // Tick while stopped changes nothing.
        send_item(make_cmd(sfs_pkg::CMD_TICK, 16'hFFFF, 8'd0, 9'd1, 16'd1, 1'b0, 1'b0, 8'd0));
        // Start a three-frame one-shot clip, flushing the (empty) queue.
        send_item(make_cmd(sfs_pkg::CMD_PLAY, 16'd0, 8'd5, 9'd3, 16'd1, 1'b0, 1'b1, 8'd0));
        // Fill the event table; the ninth add finds it full.
        send_item(make_cmd(sfs_pkg::CMD_ADD_EVENT, 16'd0, 8'd5, 9'd1, 16'd1, 1'b0, 1'b0, 8'd1));
        send_item(make_cmd(sfs_pkg::CMD_ADD_EVENT, 16'd0, 8'd5, 9'd1, 16'd1, 1'b0, 1'b0, 8'd2));
        send_item(make_cmd(sfs_pkg::CMD_ADD_EVENT, 16'd0, 8'd5, 9'd1, 16'd1, 1'b0, 1'b0, 8'd2));
        send_item(make_cmd(sfs_pkg::CMD_ADD_EVENT, 16'd0, 8'd7, 9'd1, 16'd1, 1'b0, 1'b0, 8'd0));
        send_item(make_cmd(sfs_pkg::CMD_ADD_EVENT, 16'd0, 8'hFF, 9'd1, 16'd1, 1'b0, 1'b0,
                           8'hFF));
        send_item(make_cmd(sfs_pkg::CMD_ADD_EVENT, 16'd0, 8'd5, 9'd1, 16'd1, 1'b0, 1'b0, 8'd0));
        send_item(make_cmd(sfs_pkg::CMD_ADD_EVENT, 16'd0, 8'd9, 9'd1, 16'd1, 1'b0, 1'b0, 8'd1));
        send_item(make_cmd(sfs_pkg::CMD_ADD_EVENT, 16'd0, 8'd5, 9'd1, 16'd1, 1'b0, 1'b0, 8'd1));
        send_item(make_cmd(sfs_pkg::CMD_ADD_EVENT, 16'd0, 8'd1, 9'd1, 16'd1, 1'b0, 1'b0, 8'd1));
        // Advance through the clip: exact threshold, zero step, big step,
        // then the end of a one-shot clip holds the last frame and fires.
        send_item(make_cmd(sfs_pkg::CMD_TICK, 16'd1, 8'd0, 9'd1, 16'd1, 1'b0, 1'b0, 8'd0));
        send_item(make_cmd(sfs_pkg::CMD_TICK, 16'd0, 8'd0, 9'd1, 16'd1, 1'b0, 1'b0, 8'd0));
        send_item(make_cmd(sfs_pkg::CMD_TICK, 16'hFFFF, 8'd0, 9'd1, 16'd1, 1'b0, 1'b0, 8'd0));
        send_item(make_cmd(sfs_pkg::CMD_TICK, 16'd1, 8'd0, 9'd1, 16'd1, 1'b0, 1'b0, 8'd0));
        // Fill the clip queue with edge descriptors; the fifth push drops.
        send_item(make_cmd(sfs_pkg::CMD_ENQUEUE, 16'd0, 8'd7, 9'd0, 16'd0, 1'b1, 1'b0, 8'd0));
        send_item(make_cmd(sfs_pkg::CMD_ENQUEUE, 16'd0, 8'hFF, 9'h1FF, 16'hFFFF, 1'b0, 1'b0,
                           8'd0));
        send_item(make_cmd(sfs_pkg::CMD_ENQUEUE, 16'd0, 8'd0, 9'd256, 16'd1, 1'b1, 1'b0, 8'd0));
        send_item(make_cmd(sfs_pkg::CMD_ENQUEUE, 16'd0, 8'd5, 9'd1, 16'd0, 1'b0, 1'b0, 8'd0));
        send_item(make_cmd(sfs_pkg::CMD_ENQUEUE, 16'd0, 8'd8, 9'd2, 16'd2, 1'b1, 1'b0, 8'd0));
        // Zero period advances on every tick: pop a queued clip, then the next one.
        send_item(make_cmd(sfs_pkg::CMD_PLAY, 16'd0, 8'd9, 9'd1, 16'd0, 1'b0, 1'b0, 8'd0));
        send_item(make_cmd(sfs_pkg::CMD_TICK, 16'd0, 8'd0, 9'd1, 16'd1, 1'b0, 1'b0, 8'd0));
        send_item(make_cmd(sfs_pkg::CMD_TICK, 16'd0, 8'd0, 9'd1, 16'd1, 1'b0, 1'b0, 8'd0));
        send_item(make_cmd(sfs_pkg::CMD_STOP, 16'd0, 8'd0, 9'd1, 16'd1, 1'b0, 1'b0, 8'd0));
        send_item(make_cmd(sfs_pkg::CMD_TICK, 16'd3, 8'd0, 9'd1, 16'd1, 1'b0, 1'b0, 8'd0));
        send_item(make_cmd(sfs_pkg::CMD_CLEAR_EVENTS, 16'd0, 8'd0, 9'd1, 16'd1, 1'b0, 1'b0,
                           8'd0));
        send_item(make_cmd(CMD_SPARE_6, 16'hFFFF, 8'hFF, 9'h1FF, 16'hFFFF, 1'b1, 1'b1, 8'hFF));
        send_item(make_cmd(CMD_SPARE_7, 16'd0, 8'd0, 9'd0, 16'd0, 1'b0, 1'b0, 8'd0));
        // Play with flush drops whatever is still queued.
        send_item(make_cmd(sfs_pkg::CMD_PLAY, 16'd0, 8'd2, 9'd2, 16'd2, 1'b1, 1'b1, 8'd0));

        // Full gain: park the accumulator just under the longest period,
        // then a full step overflows it and must saturate.
        write_gain(16'hFFFF);
        send_item(make_cmd(sfs_pkg::CMD_PLAY, 16'd0, 8'd3, 9'd2, 16'hFFFF, 1'b1, 1'b1, 8'd0));
        send_item(make_cmd(sfs_pkg::CMD_TICK, 16'd255, 8'd0, 9'd1, 16'd1, 1'b0, 1'b0, 8'd0));
        send_item(make_cmd(sfs_pkg::CMD_TICK, 16'hFFFF, 8'd0, 9'd1, 16'd1, 1'b0, 1'b0, 8'd0));
        send_item(make_cmd(sfs_pkg::CMD_TICK, 16'hFFFF, 8'd0, 9'd1, 16'd1, 1'b0, 1'b0, 8'd0));

        // Random part: three idle mixes, each walking through five gains.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin snd_idle_pct = 9;  rcv_idle_pct = 79; end
                1: begin snd_idle_pct = 79; rcv_idle_pct = 9;  end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            if (phase == 2) begin
                // Hold the output off for a long stretch while the sender keeps
                // pushing, so the block backs up into its input; then pause.
                hold_left = 200;
                repeat (40) send_item(random_cmd());
                drain();
            end
            for (int chunk = 0; chunk < 5; chunk++) begin
                case (chunk)
                    0:       g = 16'd0;
                    1:       g = 16'hFFFF;
                    2:       g = 16'd1;
                    3:       g = 16'($urandom);
                    default: g = sfs_pkg::GAIN_RESET;
                endcase
                write_gain(g);
                repeat (104) send_item(random_cmd());
            end
        end

        drain();
        repeat (LATENCY + 4) @(posedge aclk);

        $display("Covered %0d commands: directed edges, saturation, three idle mixes,",
                 items_sent);
        $display("five gains each and a long output stall; %0d statuses checked, %0d %s",
                 n_checked, n_fired, $sformatf("with events, %0d dropped pushes", n_dropped));
        if (err_cnt == 0 && due_cnt == 0) begin
            $display("** sprite_frame_sequencer: PASSED **");
        end else begin
            $display("** sprite_frame_sequencer: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Timeout with %0d statuses still outstanding", due_cnt);
        $display("** sprite_frame_sequencer: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
src/sfs_pkg.sv
src/sfs_event_table.sv
src/sprite_frame_sequencer.sv
verif/sfs_checker.sv
verif/tb.sv
